// ===== hdl/fshp_pkg.sv =====
// fshp_pkg: shared types and constants for the fire strip heat propagator
// no dependencies; imported by every module of the block
package fshp_pkg;

    localparam int HEAT_W     = 6;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int INTERVAL_W = 16;

    localparam logic [31:0]           RNG_SEED       = 32'h9E37_79B9;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd33;

    localparam logic ACT_FRAME = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // column move codes, r mod 3
    localparam logic [1:0] SHIFT_LEFT  = 2'd0;
    localparam logic [1:0] SHIFT_NONE  = 2'd1;
    localparam logic [1:0] SHIFT_RIGHT = 2'd2;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic [6:0]  read_x;
        logic [4:0]  read_y;
    } t_in_item;

    typedef struct packed {
        logic              propagated;
        logic [HEAT_W-1:0] heat;
        logic              visible;
    } t_out_item;

    typedef struct packed {
        logic [1:0] shift;
        logic [1:0] dec;
    } t_draw;

endpackage

// ===== hdl/fshp_heat_mem.sv =====
// fshp_heat_mem: heat cell storage, one write port and one registered read port
// depends on fshp_pkg for the cell width
module fshp_heat_mem #(
    parameter int DEPTH = 3968,
    parameter int AW    = 12
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [fshp_pkg::HEAT_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [fshp_pkg::HEAT_W-1:0] o_rdata
);
    import fshp_pkg::*;

    logic [HEAT_W-1:0] r_mem [DEPTH];
    logic [HEAT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/fshp_rng.sv =====
// fshp_rng: xorshift32 generator with registered column move and decay per draw
// depends on fshp_pkg for the seed and the draw struct
module fshp_rng (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    output fshp_pkg::t_draw o_draw
);
    import fshp_pkg::*;

    logic [31:0] r_state;
    t_draw       r_draw;
    logic [31:0] n_s1;
    logic [31:0] n_s2;
    logic [31:0] n_state;

    // residue mod 3 by folding, 2^(2k) is 1 mod 3
    function automatic logic [1:0] mod3(input logic [31:0] v);
        logic [16:0] a;
        logic [9:0]  b;
        logic [6:0]  c;
        logic [4:0]  d;
        logic [3:0]  e;
        logic [2:0]  f;
        logic [1:0]  m;
        a = {1'b0, v[31:16]} + {1'b0, v[15:0]};
        b = {1'b0, a[16:8]} + {2'b0, a[7:0]};
        c = {1'b0, b[9:4]} + {3'b0, b[3:0]};
        d = {2'b0, c[6:4]} + {1'b0, c[3:0]};
        e = {1'b0, d[4:2]} + {2'b0, d[1:0]};
        f = {1'b0, e[3:2]} + {1'b0, e[1:0]};
        unique case (f)
            3'd0, 3'd3, 3'd6: m = 2'd0;
            3'd1, 3'd4, 3'd7: m = 2'd1;
            default:          m = 2'd2;
        endcase
        return m;
    endfunction

    always_comb begin
        n_s1    = r_state ^ (r_state << 13);
        n_s2    = n_s1 ^ (n_s1 >> 17);
        n_state = n_s2 ^ (n_s2 << 5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RNG_SEED;
        end else if (i_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_draw.shift <= mod3(n_state);
            r_draw.dec   <= mod3({2'b00, n_state[31:2]});
        end
    end

    assign o_draw = r_draw;

endmodule

// ===== hdl/fire_strip_heat_propagator.sv =====
// fire_strip_heat_propagator: top level, sequencer, propagation pipeline, config port
// depends on fshp_pkg, fshp_heat_mem and fshp_rng
//
// usage
//   input channel (i_in_valid / o_in_stall / i_in_data) takes frame and read
//   transactions; output channel (o_out_valid / i_out_stall / o_out_data) gives
//   one result per transaction, in order
//   frame transaction: bottom row goes to full heat; if now_ms - last time is at
//   least interval_ms, one propagation pass runs, one cell per cycle through
//   all (STRIP_HEIGHT-1)*STRIP_WIDTH cells of the heat memory (3968 by default)
//   steps after accept: EVAL, then RDATA for a read, or PASS and DRAIN for a
//   pass, then DONE, which loads the output register once it frees and goes
//   back to IDLE, where the next transaction is taken
//   one transaction at a time; the next one is taken as soon as the result
//   sits in the output register, even while the receiver stalls it
//   the output register holds its result while i_out_stall is high; a second
//   finished result waits inside until the register frees
//   reset: synchronous clearing sweep of the heat memory, one cell per cycle
//   over all (STRIP_HEIGHT-1)*STRIP_WIDTH cells, o_in_stall high meanwhile;
//   the bottom row is kept as a flag and not stored
//   config: interval_ms at byte address 0; writes only while idle, left to the user
module fire_strip_heat_propagator #(
    parameter int STRIP_WIDTH  = 128,
    parameter int STRIP_HEIGHT = 32,
    parameter int HEAT_LEVELS  = 37
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fshp_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fshp_pkg::t_out_item                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fshp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [fshp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fshp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import fshp_pkg::*;

    localparam int DEPTH = (STRIP_HEIGHT - 1) * STRIP_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int X_W   = $clog2(STRIP_WIDTH);
    localparam int Y_W   = $clog2(STRIP_HEIGHT);

    localparam logic [HEAT_W-1:0] HOT      = HEAT_W'(HEAT_LEVELS - 1);
    localparam logic [X_W-1:0]    X_LAST   = X_W'(STRIP_WIDTH - 1);
    localparam logic [Y_W-1:0]    Y_LAST   = Y_W'(STRIP_HEIGHT - 2);
    localparam logic [AW-1:0]     A_LAST   = AW'(DEPTH - 1);
    localparam logic [AW-1:0]     A_WIDTH  = AW'(STRIP_WIDTH);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EVAL  = 3'd2;
    localparam logic [2:0] ST_RDATA = 3'd3;
    localparam logic [2:0] ST_PASS  = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]            r_state;
    t_in_item              r_item;
    logic                  r_hot;
    logic [31:0]           r_last;
    logic [INTERVAL_W-1:0] r_interval;
    logic [AW-1:0]         r_clr;
    logic [X_W-1:0]        r_x;
    logic [Y_W-1:0]        r_y;
    logic [AW-1:0]         r_base;
    logic                  r_s1_vld;
    logic [X_W-1:0]        r_s1_x;
    logic [AW-1:0]         r_s1_base;
    logic                  r_s1_bot;
    logic                  r_rd_ok;
    logic                  r_rd_bot;
    t_out_item             r_res;
    t_out_item             r_out;
    logic                  r_out_valid;

    logic                  in_acc;
    logic                  cfg_wr;
    logic                  rng_adv;
    t_draw                 draw;
    logic [HEAT_W-1:0]     mem_q;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [HEAT_W-1:0]     mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [AW-1:0]         src_addr;
    logic [AW-1:0]         item_addr;
    logic [31:0]           n_diff;
    logic [X_W-1:0]        n_col;
    logic [HEAT_W-1:0]     n_src;
    logic [HEAT_W-1:0]     n_val;
    logic [HEAT_W-1:0]     n_rd_heat;
    logic                  n_x_ok;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign rng_adv = (r_state == ST_PASS);

    fshp_rng u_rng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (rng_adv),
        .o_draw  (draw)
    );

    fshp_heat_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    // address and range checks
    always_comb begin
        src_addr  = AW'({1'b0, r_base} + (AW + 1)'(STRIP_WIDTH) + (AW + 1)'(r_x));
        item_addr = AW'(r_item.read_y) * A_WIDTH + AW'(r_item.read_x);
        n_x_ok    = 32'(r_item.read_x) < STRIP_WIDTH;
        n_diff    = r_item.now_ms - r_last;
        mem_raddr = (r_state == ST_PASS) ? src_addr : item_addr;
    end

    // stage 1 of the pass: move and decay; also the clearing write and the read result
    always_comb begin
        n_src = r_s1_bot ? HOT : mem_q;
        n_val = (n_src > HEAT_W'(draw.dec)) ? (n_src - HEAT_W'(draw.dec)) : '0;
        unique case (draw.shift)
            SHIFT_LEFT:  n_col = (r_s1_x == '0) ? r_s1_x : (r_s1_x - X_W'(1));
            SHIFT_RIGHT: n_col = (r_s1_x == X_LAST) ? r_s1_x : (r_s1_x + X_W'(1));
            default:     n_col = r_s1_x;
        endcase
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else begin
            mem_we    = r_s1_vld;
            mem_waddr = r_s1_base + AW'(n_col);
            mem_wdata = n_val;
        end
        n_rd_heat = r_rd_ok ? mem_q : ((r_rd_bot && r_hot) ? HOT : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_hot       <= 1'b0;
            r_last      <= '0;
            r_x         <= '0;
            r_y         <= '0;
            r_base      <= '0;
            r_s1_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_vld <= (r_state == ST_PASS);
            if ((r_state == ST_DONE) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == A_LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_in_data.action == ACT_FRAME) begin
                            r_hot <= 1'b1;
                        end
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (r_item.action == ACT_FRAME) begin
                        if (n_diff >= 32'(r_interval)) begin
                            r_last  <= r_item.now_ms;
                            r_x     <= '0;
                            r_y     <= '0;
                            r_base  <= '0;
                            r_state <= ST_PASS;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end else begin
                        r_state <= ST_RDATA;
                    end
                end
                ST_RDATA: begin
                    r_state <= ST_DONE;
                end
                ST_PASS: begin
                    if (r_x == X_LAST) begin
                        r_x    <= '0;
                        r_y    <= r_y + Y_W'(1);
                        r_base <= r_base + A_WIDTH;
                        if (r_y == Y_LAST) begin
                            r_state <= ST_DRAIN;
                        end
                    end else begin
                        r_x <= r_x + X_W'(1);
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_data;
        end
        if (r_state == ST_PASS) begin
            r_s1_x    <= r_x;
            r_s1_base <= r_base;
            r_s1_bot  <= (r_y == Y_LAST);
        end
        if (r_state == ST_EVAL) begin
            r_rd_ok  <= n_x_ok && (32'(r_item.read_y) < STRIP_HEIGHT - 1);
            r_rd_bot <= n_x_ok && (32'(r_item.read_y) == STRIP_HEIGHT - 1);
            r_res    <= '0;
        end
        if (r_state == ST_RDATA) begin
            r_res.propagated <= 1'b0;
            r_res.heat       <= n_rd_heat;
            r_res.visible    <= (n_rd_heat > HEAT_W'(1));
        end
        if (r_state == ST_DRAIN) begin
            r_res.propagated <= 1'b1;
        end
        if ((r_state == ST_DONE) && (!r_out_valid || !i_out_stall)) begin
            r_out <= r_res;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
        end else if (cfg_wr && (paddr[2] == 1'b0)) begin
            r_interval <= pwdata[INTERVAL_W-1:0];
        end
    end

    assign prdata      = (paddr[2] == 1'b0) ? CFG_DATA_W'(r_interval) : '0;
    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/fshp_checker.sv =====
// fshp_checker: port-level assertions for the fire strip heat propagator
// depends on fshp_pkg; bound to the top level at the end of this file
module fshp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input fshp_pkg::t_out_item o_out_data,
    input logic                pready
);
    import fshp_pkg::*;

    // held result while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while busy");

    a_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.visible == (o_out_data.heat > HEAT_W'(1))))
        else $error("visible flag mismatch");

    a_frame_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.propagated) |-> (o_out_data.heat == '0))
        else $error("frame result carries heat");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind fire_strip_heat_propagator fshp_checker u_fshp_checker (.*);
